/* rtl/id3v2_tag_header_walker_defines.svh */
// assertion macros shared by the walker's checker
`ifndef ID3V2_TAG_HEADER_WALKER_DEFINES_SVH
`define ID3V2_TAG_HEADER_WALKER_DEFINES_SVH

// same-cycle implication, off during reset
`define ID3W_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define ID3W_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// holds in the cycle after any reset cycle
`define ID3W_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("post-reset check failed");

`endif

/* rtl/id3w_pkg.sv */
// types and constants of the tag header walker
`default_nettype none

package id3w_pkg;

  localparam int TAG_HDR_LEN     = 10;
  localparam int OLD_FRAME_HDR   = 6;
  localparam int NEW_FRAME_HDR   = 10;
  localparam int SIZE_BYTE_FIRST = 6;
  localparam int FIFO_DEPTH      = 4;
  localparam int PTR_W           = $clog2(FIFO_DEPTH);
  localparam int CNT_W           = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FRAME,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR_OK  = 3'd0,
    KIND_HDR_ERR = 3'd1,
    KIND_FRAME   = 3'd2,
    KIND_PAD     = 3'd3,
    KIND_END     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] frame_id;
    logic [31:0] frame_size;
    logic [7:0]  frame_flags;
    logic [27:0] tag_size;
    logic [7:0]  major_version;
    logic [7:0]  revision;
    logic [3:0]  tag_flags;
    logic        footer_conflict;
    logic        last_of_run;
  } result_t;

  // results raised by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

/* rtl/id3w_if.sv */
// byte input and result output channel interfaces
`default_nettype none

interface id3w_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       tag_start;

  modport source (output valid, output data_byte, output tag_start, input ready);
  modport sink (input valid, input data_byte, input tag_start, output ready);
endinterface

interface id3w_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] frame_id;
  logic [31:0] frame_size;
  logic [7:0]  frame_flags;
  logic [27:0] tag_size;
  logic [7:0]  major_version;
  logic [7:0]  revision;
  logic [3:0]  tag_flags;
  logic        footer_conflict;
  logic        last_of_run;

  modport source (output valid, output kind, output frame_id, output frame_size,
                  output frame_flags, output tag_size, output major_version,
                  output revision, output tag_flags, output footer_conflict,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input frame_id, input frame_size,
                input frame_flags, input tag_size, input major_version,
                input revision, input tag_flags, input footer_conflict,
                input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/id3w_parser.sv */
// tag header and frame header parse state, one byte per transfer
`default_nettype none

module id3w_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            tag_start,
  output id3w_pkg::push_t      push
);
  import id3w_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [63:0] collected_bytes, collected_bytes_next;
  logic        size_byte_bad, size_byte_bad_next;
  logic [27:0] held_tag_size, held_tag_size_next;
  logic [7:0]  held_version, held_version_next;
  logic [7:0]  held_revision, held_revision_next;
  logic [3:0]  held_tag_flags, held_tag_flags_next;
  logic [27:0] tag_position, tag_position_next;
  logic [31:0] payload_left, payload_left_next;
  logic [7:0]  flag_acc, flag_acc_next;

  function automatic logic [27:0] synchsafe(input logic [31:0] raw);
    synchsafe = {raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
  endfunction

  function automatic logic [3:0] hdr_len(input logic [7:0] version);
    hdr_len = (version <= 8'd2) ? 4'(OLD_FRAME_HDR) : 4'(NEW_FRAME_HDR);
  endfunction

  function automatic result_t make_res(input kind_t kind, input logic [31:0] id,
                                       input logic [31:0] size, input logic [7:0] flags,
                                       input logic conflict, input logic [27:0] tsize,
                                       input logic [7:0] ver, input logic [7:0] rev,
                                       input logic [3:0] tflags);
    result_t r;
    r.kind            = kind;
    r.frame_id        = id;
    r.frame_size      = size;
    r.frame_flags     = flags;
    r.tag_size        = tsize;
    r.major_version   = ver;
    r.revision        = rev;
    r.tag_flags       = tflags;
    r.footer_conflict = conflict;
    r.last_of_run     = 1'b0;
    make_res = r;
  endfunction

  phase_t      ph;
  logic [3:0]  bi;
  logic [63:0] cb;
  logic        bad;
  logic [3:0]  hl;
  logic [27:0] hdr_size;
  logic [31:0] fr_id, fr_size;
  logic [7:0]  fr_flags;
  logic [32:0] next_start;
  logic [27:0] limit;
  result_t     res0, res1;
  logic [1:0]  n;

  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    collected_bytes_next = collected_bytes;
    size_byte_bad_next   = size_byte_bad;
    held_tag_size_next   = held_tag_size;
    held_version_next    = held_version;
    held_revision_next   = held_revision;
    held_tag_flags_next  = held_tag_flags;
    tag_position_next    = tag_position;
    payload_left_next    = payload_left;
    flag_acc_next        = flag_acc;
    res0                 = '0;
    res1                 = '0;
    n                    = 2'd0;
    hl                   = hdr_len(held_version);
    hdr_size             = '0;
    fr_id                = '0;
    fr_size              = '0;
    fr_flags             = '0;
    next_start           = '0;
    limit                = '0;

    // a start mark restarts the header parse from any phase
    ph  = tag_start ? PH_HEADER : phase;
    bi  = tag_start ? 4'd0 : byte_index;
    cb  = tag_start ? 64'd0 : collected_bytes;
    bad = tag_start ? 1'b0 : size_byte_bad;

    if (accept) begin
      phase_next           = ph;
      byte_index_next      = bi;
      collected_bytes_next = cb;
      size_byte_bad_next   = bad;

      case (ph)
        PH_HEADER: begin
          collected_bytes_next = {cb[55:0], data_byte};
          size_byte_bad_next   = bad | ((bi >= 4'(SIZE_BYTE_FIRST)) & data_byte[7]);
          byte_index_next      = bi + 4'd1;
          if (bi == 4'(TAG_HDR_LEN - 1)) begin
            hdr_size            = synchsafe(collected_bytes_next[31:0]);
            held_version_next   = collected_bytes_next[55:48];
            held_revision_next  = collected_bytes_next[47:40];
            held_tag_flags_next = collected_bytes_next[39:36];
            hl                  = hdr_len(held_version_next);
            byte_index_next     = 4'd0;
            if (size_byte_bad_next || hdr_size == 28'd0) begin
              held_tag_size_next = '0;
              res0 = make_res(KIND_HDR_ERR, '0, '0, '0, 1'b0, '0, held_version_next,
                              held_revision_next, held_tag_flags_next);
              n          = 2'd1;
              phase_next = PH_IDLE;
            end else begin
              held_tag_size_next = hdr_size;
              res0 = make_res(KIND_HDR_OK, '0, '0, '0, 1'b0, hdr_size, held_version_next,
                              held_revision_next, held_tag_flags_next);
              n = 2'd1;
              if (hdr_size <= {24'd0, hl}) begin
                res1 = make_res(KIND_END, '0, '0, '0, 1'b0, hdr_size, held_version_next,
                                held_revision_next, held_tag_flags_next);
                n          = 2'd2;
                phase_next = PH_IDLE;
              end else begin
                phase_next           = PH_FRAME;
                tag_position_next    = '0;
                collected_bytes_next = '0;
                flag_acc_next        = '0;
              end
            end
          end
        end

        PH_FRAME: begin
          if (bi == 4'd0 && data_byte == 8'd0) begin
            // padding at a frame start
            res0 = make_res(KIND_PAD, '0, '0, '0, held_tag_flags[0], held_tag_size,
                            held_version, held_revision, held_tag_flags);
            n          = 2'd1;
            phase_next = PH_IDLE;
          end else begin
            if (bi < 4'd8) begin
              collected_bytes_next = {cb[55:0], data_byte};
            end else if (bi == 4'd8) begin
              flag_acc_next = (held_version == 8'd3) ? {data_byte[7:5], 5'd0}
                                                     : {data_byte[6:4], 5'd0};
            end else begin
              flag_acc_next = flag_acc | ((held_version == 8'd3)
                ? {3'd0, data_byte[7:5], 2'd0}
                : {3'd0, data_byte[3], data_byte[2], data_byte[6], data_byte[1:0]});
            end
            byte_index_next = bi + 4'd1;
            if (byte_index_next == hl) begin
              if (held_version <= 8'd2) begin
                fr_id    = {8'd0, collected_bytes_next[47:24]};
                fr_size  = {8'd0, collected_bytes_next[23:0]};
                fr_flags = '0;
              end else begin
                fr_id    = collected_bytes_next[63:32];
                fr_size  = (held_version == 8'd3) ? collected_bytes_next[31:0]
                                                  : {4'd0, synchsafe(collected_bytes_next[31:0])};
                fr_flags = flag_acc_next;
              end
              res0 = make_res(KIND_FRAME, fr_id, fr_size, fr_flags, 1'b0, held_tag_size,
                              held_version, held_revision, held_tag_flags);
              n                    = 2'd1;
              byte_index_next      = 4'd0;
              collected_bytes_next = '0;
              flag_acc_next        = '0;
              next_start = {5'd0, tag_position} + {29'd0, hl} + {1'b0, fr_size};
              limit      = held_tag_size - {24'd0, hl};
              // tag ends once the next frame start reaches the limit
              if (next_start >= {5'd0, limit}) begin
                res1 = make_res(KIND_END, '0, '0, '0, 1'b0, held_tag_size, held_version,
                                held_revision, held_tag_flags);
                n          = 2'd2;
                phase_next = PH_IDLE;
              end else begin
                tag_position_next = next_start[27:0];
                payload_left_next = fr_size;
                phase_next        = (fr_size != 32'd0) ? PH_PAYLOAD : PH_FRAME;
              end
            end
          end
        end

        PH_PAYLOAD: begin
          if (payload_left != 32'd0) begin
            payload_left_next = payload_left - 32'd1;
          end
          if (payload_left_next == 32'd0) begin
            phase_next      = PH_FRAME;
            byte_index_next = 4'd0;
          end
        end

        default: begin
        end
      endcase
    end

    if (n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
    push.count  = n;
    push.first  = res0;
    push.second = res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_index      <= '0;
      collected_bytes <= '0;
      size_byte_bad   <= 1'b0;
      held_tag_size   <= '0;
      held_version    <= '0;
      held_revision   <= '0;
      held_tag_flags  <= '0;
      tag_position    <= '0;
      payload_left    <= '0;
      flag_acc        <= '0;
    end else begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      collected_bytes <= collected_bytes_next;
      size_byte_bad   <= size_byte_bad_next;
      held_tag_size   <= held_tag_size_next;
      held_version    <= held_version_next;
      held_revision   <= held_revision_next;
      held_tag_flags  <= held_tag_flags_next;
      tag_position    <= tag_position_next;
      payload_left    <= payload_left_next;
      flag_acc        <= flag_acc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/id3w_out_fifo.sv */
// result queue, up to two writes and one read per cycle
`default_nettype none

module id3w_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire id3w_pkg::push_t   push,
  input  wire logic              pop,
  output id3w_pkg::result_t      head,
  output logic                   not_empty,
  output logic                   has_room
);
  import id3w_pkg::*;

  result_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  // room for the two results a single byte can raise
  assign has_room  = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/id3v2_tag_header_walker.sv */
// tag header and frame header walker top level
//
// stream: one tag byte per transfer, tag_start high on byte 0 of a tag
// header; a start mark restarts the parse in any phase. bytes outside a
// tag (no start mark seen, or after an error, padding or tag end) are
// taken and dropped.
// result: one result item per transfer. a byte raises zero, one or two
// results; last_of_run marks the final one of each byte.
// output: a result is written into the result queue when the byte that
// raised it is transferred, and is offered from the head of the queue.
// throughput: one byte per cycle. results wait in a four-entry queue;
// stream.ready falls while more than two results are pending. under a
// stalled receiver, bytes that raise no result keep flowing until that
// point, then the sender is held off and no result is lost.
// reset: parse goes idle with all held header values zero and the queue
// is emptied; the next tag begins at the next start mark.
`default_nettype none

module id3v2_tag_header_walker (
  input  wire logic   clk,
  input  wire logic   rst,
  id3w_in_if.sink     stream,
  id3w_out_if.source  result
);
  import id3w_pkg::*;

  logic    accept;
  logic    pop;
  logic    has_room;
  logic    not_empty;
  push_t   push;
  result_t head;

  assign stream.ready = has_room;
  assign accept       = stream.valid & has_room;
  assign result.valid = not_empty;
  assign pop          = not_empty & result.ready;

  id3w_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (stream.data_byte),
    .tag_start (stream.tag_start),
    .push      (push)
  );

  id3w_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  assign result.kind            = head.kind;
  assign result.frame_id        = head.frame_id;
  assign result.frame_size      = head.frame_size;
  assign result.frame_flags     = head.frame_flags;
  assign result.tag_size        = head.tag_size;
  assign result.major_version   = head.major_version;
  assign result.revision        = head.revision;
  assign result.tag_flags       = head.tag_flags;
  assign result.footer_conflict = head.footer_conflict;
  assign result.last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

/* rtl/id3w_checker.sv */
// port-level checks on the walker, bound to the top level
`default_nettype none
`include "id3v2_tag_header_walker_defines.svh"

module id3w_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  kind,
  input wire logic [31:0] frame_id,
  input wire logic [3:0]  tag_flags,
  input wire logic        footer_conflict,
  input wire logic        last_of_run
);
  import id3w_pkg::*;

  // a stalled result stays offered
  `ID3W_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // conflict only on padding, and only with the footer flag set
  `ID3W_ASSERT_IMPLY(a_conflict_pad, clk, rst, out_valid && footer_conflict, kind == KIND_PAD && tag_flags[0])

  // only frame results carry an identifier
  `ID3W_ASSERT_IMPLY(a_id_frame_only, clk, rst, out_valid && kind != KIND_FRAME, frame_id == 32'd0)

  // tag end always closes the run of its byte
  `ID3W_ASSERT_IMPLY(a_end_last, clk, rst, out_valid && kind == KIND_END, last_of_run)

  // queue is empty after reset
  `ID3W_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !out_valid)

endmodule

bind id3v2_tag_header_walker id3w_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .kind            (result.kind),
  .frame_id        (result.frame_id),
  .tag_flags       (result.tag_flags),
  .footer_conflict (result.footer_conflict),
  .last_of_run     (result.last_of_run)
);

`default_nettype wire
